### hdl/tcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_pkg: shared types and constants of the two-car dispatcher
// Car state record, step result, sequencer codes, key codes and register
// indexes used by the dispatcher and its car step logic.
// ----------------------------------------------------------------------------
package tcd_pkg;

	localparam int FLOORS = 4;

	localparam logic [2:0] FLOOR_BOTTOM = 3'd1;
	localparam logic [2:0] FLOOR_TOP    = 3'd4;

	localparam logic [7:0] TRAVEL_RESET = 8'd35;
	localparam logic [7:0] DOOR_RESET   = 8'd70;

	// Request kinds.
	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_PRESS = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_TRAVEL = 1'b0;
	localparam logic CFG_DOOR   = 1'b1;

	// Matrix key codes.
	localparam logic [7:0] KEY_A1  = 8'h11;
	localparam logic [7:0] KEY_A2  = 8'h21;
	localparam logic [7:0] KEY_A3  = 8'h41;
	localparam logic [7:0] KEY_A4  = 8'h81;
	localparam logic [7:0] KEY_B1  = 8'h12;
	localparam logic [7:0] KEY_B2  = 8'h22;
	localparam logic [7:0] KEY_B3  = 8'h42;
	localparam logic [7:0] KEY_B4  = 8'h82;
	localparam logic [7:0] KEY_HU1 = 8'h14;
	localparam logic [7:0] KEY_HU2 = 8'h24;
	localparam logic [7:0] KEY_HU3 = 8'h84;
	localparam logic [7:0] KEY_HD2 = 8'h44;
	localparam logic [7:0] KEY_HD3 = 8'h18;
	localparam logic [7:0] KEY_HD4 = 8'h28;

	// Step of the current car within its turn.
	typedef enum logic [1:0] {
		SUB_DECIDE      = 2'd0,
		SUB_DOOR_OWN    = 2'd1,
		SUB_TRAVEL      = 2'd2,
		SUB_DOOR_ARRIVE = 2'd3
	} sub_t;

	typedef struct packed {
		logic [2:0] pos;
		logic [2:0] target;
		logic       up;
		logic       idle;
		logic       stop;
		logic [3:0] cab_up;
		logic [3:0] cab_dn;
	} car_t;

	typedef struct packed {
		car_t       car;
		logic [3:0] hall_up;
		logic [3:0] hall_dn;
		sub_t       sub_next;
		logic       swap;
		logic       load_wait;
		logic       wait_door;
	} step_t;

	// One-hot mask of a floor, zero outside 1..4.
	function automatic logic [3:0] fbit(input logic [2:0] f);
		logic [3:0] m;
		case (f)
			3'd1:    m = 4'b0001;
			3'd2:    m = 4'b0010;
			3'd3:    m = 4'b0100;
			3'd4:    m = 4'b1000;
			default: m = 4'b0000;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

### hdl/tcd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_if: channel interfaces of the two-car dispatcher
// Request, result and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface tcd_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] key_code;

	modport source (output valid, req_type, key_code, input ready);
	modport sink (input valid, req_type, key_code, output ready);
endinterface

interface tcd_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] floor_a;
	logic [2:0] floor_b;
	logic       going_up_a;
	logic       going_up_b;
	logic       door_open_a;
	logic       door_open_b;
	logic [3:0] car_lamps_a;
	logic [3:0] car_lamps_b;
	logic [3:0] hall_up_lamps;
	logic [3:0] hall_down_lamps;
	logic       waiting;

	modport source (output valid, floor_a, floor_b, going_up_a, going_up_b, door_open_a,
		door_open_b, car_lamps_a, car_lamps_b, hall_up_lamps, hall_down_lamps, waiting,
		input ready);
	modport sink (input valid, floor_a, floor_b, going_up_a, going_up_b, door_open_a,
		door_open_b, car_lamps_a, car_lamps_b, hall_up_lamps, hall_down_lamps, waiting,
		output ready);
endinterface

interface tcd_cfg_if;
	logic       valid;
	logic       ready;
	logic       addr;
	logic [7:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### hdl/tcd_car_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_car_step: one turn of the active car
// Decide turn with idle hall search and LOOK scan, or completion of a door
// stay or a one-floor move. Purely combinational.
// ----------------------------------------------------------------------------
module tcd_car_step (
	input  tcd_pkg::car_t  cur,
	input  logic [2:0]     other_target,
	input  logic [3:0]     hall_up,
	input  logic [3:0]     hall_dn,
	input  tcd_pkg::sub_t  sub,
	input  logic           finish,
	output tcd_pkg::step_t step
);
	import tcd_pkg::*;

	always_comb begin
		car_t       c;
		logic [3:0] hu;
		logic [3:0] hd;
		logic [3:0] b;
		logic [3:0] hall_any;
		logic       found;
		logic [2:0] t;

		c        = cur;
		hu       = hall_up;
		hd       = hall_dn;
		b        = 4'b0000;
		hall_any = hall_up | hall_dn;
		found    = 1'b0;
		t        = cur.pos;
		step.sub_next  = SUB_DECIDE;
		step.swap      = 1'b1;
		step.load_wait = 1'b0;
		step.wait_door = 1'b0;

		if (!finish && sub == SUB_DECIDE) begin
			// An idle car first grabs the nearest hall call behind its direction.
			if (c.idle) begin
				if (c.up) begin
					for (int i = 1; i <= FLOORS; i++) begin
						if (3'(i) <= c.pos && hall_any[i-1]) begin
							found = 1'b1;
							t     = 3'(i);
						end
					end
				end else begin
					for (int i = FLOORS; i >= 1; i--) begin
						if (3'(i) >= c.pos && hall_any[i-1]) begin
							found = 1'b1;
							t     = 3'(i);
						end
					end
				end
				if (found && other_target != t) c.target = t;
			end

			// LOOK scan ahead in the current direction.
			found = 1'b0;
			t     = c.pos;
			if (c.up) begin
				for (int i = FLOORS; i >= 1; i--) begin
					if (3'(i) >= c.pos && (c.cab_up[i-1] ||
							(hu[i-1] && other_target != 3'(i)))) begin
						found = 1'b1;
						t     = 3'(i);
					end
				end
				if (found) c.target = t;
				else c.up = 1'b0;
			end else begin
				for (int i = 1; i <= FLOORS; i++) begin
					if (3'(i) <= c.pos && (c.cab_dn[i-1] ||
							(hd[i-1] && other_target != 3'(i)))) begin
						found = 1'b1;
						t     = 3'(i);
					end
				end
				if (found) c.target = t;
				else c.up = 1'b1;
			end

			b = fbit(c.pos);
			if (c.target == c.pos) begin
				if (c.up && (hu & b) != 4'b0000) begin
					c.stop   = 1'b1;
					c.idle   = 1'b0;
					c.cab_up = c.cab_up & ~b;
					hu       = hu & ~b;
					step.load_wait = 1'b1;
					step.wait_door = 1'b1;
					step.sub_next  = SUB_DOOR_OWN;
					step.swap      = 1'b0;
				end else if (!c.up && (hd & b) != 4'b0000) begin
					c.stop   = 1'b1;
					c.idle   = 1'b0;
					c.cab_dn = c.cab_dn & ~b;
					hd       = hd & ~b;
					step.load_wait = 1'b1;
					step.wait_door = 1'b1;
					step.sub_next  = SUB_DOOR_OWN;
					step.swap      = 1'b0;
				end
			end else begin
				c.up   = (c.target > c.pos);
				c.idle = 1'b0;
				c.stop = 1'b0;
				step.load_wait = 1'b1;
				step.sub_next  = SUB_TRAVEL;
				step.swap      = 1'b0;
			end
		end else begin
			case (sub)
				SUB_TRAVEL: begin
					if (c.up) begin
						if (c.pos < FLOOR_TOP) c.pos = c.pos + 3'd1;
						b        = fbit(c.pos);
						c.cab_up = c.cab_up & ~b;
						hu       = hu & ~b;
					end else begin
						if (c.pos > FLOOR_BOTTOM) c.pos = c.pos - 3'd1;
						b        = fbit(c.pos);
						c.cab_dn = c.cab_dn & ~b;
						hd       = hd & ~b;
					end
					if (c.pos == c.target) begin
						c.stop = 1'b1;
						step.load_wait = 1'b1;
						step.wait_door = 1'b1;
						step.sub_next  = SUB_DOOR_ARRIVE;
						step.swap      = 1'b0;
					end
				end
				SUB_DOOR_ARRIVE: begin
					c.stop = 1'b0;
					if ((c.cab_up | c.cab_dn | hu | hd) == 4'b0000) c.idle = 1'b1;
				end
				default: begin
					c.stop = 1'b0;
				end
			endcase
		end

		step.car     = c;
		step.hall_up = hu;
		step.hall_dn = hd;
	end

endmodule
`default_nettype wire

### hdl/two_car_elevator_dispatch.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_car_elevator_dispatch: two cars over four floors in LOOK order
// Takes button presses and ticks, keeps both cars and all calls, and
// reports the full lamp and car status after every item.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  --------+-----+--------------------------------------------------------
//  req     | in  | req_type (tick or press), key_code
//  rsp     | out | floors, directions, doors, cab and hall lamps, waiting
//  cfg     | in  | addr 0 travel_ticks, addr 1 door_ticks, data
//
// Every item is held in an input register and the whole car turn settles
// between that register and the result register, so a new item is taken in
// every cycle while results flow out.
// Reset clears both cars to floor 1, idle, going up, all calls cleared, and
// the turn set to car A deciding; travel and door lengths go to 35 and 70.
// A stalled result holds the input register, which then throttles the request
// side; configuration writes are always taken.
// ----------------------------------------------------------------------------
module two_car_elevator_dispatch (
	input  wire logic clk,
	input  wire logic arst_n,
	tcd_req_if.sink   req,
	tcd_rsp_if.source rsp,
	tcd_cfg_if.sink   cfg
);
	import tcd_pkg::*;

	// Configuration registers.
	logic [7:0] travel_q;
	logic [7:0] door_q;

	// Input stage.
	logic       valid_s1;
	logic       req_type_s1;
	logic [7:0] key_code_s1;

	// Controller state. The turn is the active car plus its step.
	car_t       car_a_q, car_b_q;
	logic [3:0] hall_up_q, hall_dn_q;
	logic       sel_q;
	sub_t       sub_q;
	logic [7:0] wait_q;

	// Result register.
	logic       out_valid_q;
	logic [2:0] floor_a_q, floor_b_q;
	logic       going_up_a_q, going_up_b_q;
	logic       door_open_a_q, door_open_b_q;
	logic [3:0] car_lamps_a_q, car_lamps_b_q;
	logic [3:0] hall_up_lamps_q, hall_down_lamps_q;
	logic       waiting_q;

	// Next-state values.
	car_t       car_a_n, car_b_n;
	logic [3:0] hall_up_n, hall_dn_n;
	logic       sel_n;
	sub_t       sub_n;
	logic [7:0] wait_n;

	car_t       cur;
	logic [2:0] other_target;
	step_t      step;
	logic [7:0] len_raw;
	logic [7:0] wait_len;

	logic       out_free;
	logic       advance;

	// Press decode.
	logic       cab_a, cab_b;
	logic [2:0] cab_floor;
	logic [3:0] hall_up_set, hall_dn_set;

	// The result register frees up when it is empty or being taken; the input
	// stage then moves its item through the car logic into it.
	assign out_free  = !out_valid_q || rsp.ready;
	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q <= TRAVEL_RESET;
			door_q   <= DOOR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_TRAVEL: travel_q <= cfg.data;
				CFG_DOOR:   door_q   <= cfg.data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			key_code_s1 <= req.key_code;
		end
	end

	// The active car and the target of the other one, which blocks shared
	// hall calls that it already serves.
	assign cur          = sel_q ? car_b_q : car_a_q;
	assign other_target = sel_q ? car_a_q.target : car_b_q.target;

	tcd_car_step u_car_step (
		.cur          (cur),
		.other_target (other_target),
		.hall_up      (hall_up_q),
		.hall_dn      (hall_dn_q),
		.sub          (sub_q),
		.finish       (wait_q != 8'd0),
		.step         (step)
	);

	// A countdown length of zero behaves as one tick.
	assign len_raw  = step.wait_door ? door_q : travel_q;
	assign wait_len = (len_raw == 8'd0) ? 8'd1 : len_raw;

	always_comb begin
		cab_a       = 1'b0;
		cab_b       = 1'b0;
		cab_floor   = FLOOR_BOTTOM;
		hall_up_set = 4'b0000;
		hall_dn_set = 4'b0000;
		unique case (key_code_s1)
			KEY_A1:  begin cab_a = 1'b1; cab_floor = 3'd1; end
			KEY_A2:  begin cab_a = 1'b1; cab_floor = 3'd2; end
			KEY_A3:  begin cab_a = 1'b1; cab_floor = 3'd3; end
			KEY_A4:  begin cab_a = 1'b1; cab_floor = 3'd4; end
			KEY_B1:  begin cab_b = 1'b1; cab_floor = 3'd1; end
			KEY_B2:  begin cab_b = 1'b1; cab_floor = 3'd2; end
			KEY_B3:  begin cab_b = 1'b1; cab_floor = 3'd3; end
			KEY_B4:  begin cab_b = 1'b1; cab_floor = 3'd4; end
			KEY_HU1: hall_up_set = 4'b0001;
			KEY_HU2: hall_up_set = 4'b0010;
			KEY_HU3: hall_up_set = 4'b0100;
			KEY_HD2: hall_dn_set = 4'b0010;
			KEY_HD3: hall_dn_set = 4'b0100;
			KEY_HD4: hall_dn_set = 4'b1000;
			default: ;
		endcase
	end

	always_comb begin
		car_a_n   = car_a_q;
		car_b_n   = car_b_q;
		hall_up_n = hall_up_q;
		hall_dn_n = hall_dn_q;
		sel_n     = sel_q;
		sub_n     = sub_q;
		wait_n    = wait_q;

		if (req_type_s1 == REQ_PRESS) begin
			// A cab press sets an up or down call relative to where the car is
			// now; its own floor sets nothing.
			if (cab_a) begin
				if (car_a_q.pos > cab_floor)
					car_a_n.cab_dn = car_a_q.cab_dn | fbit(cab_floor);
				else if (car_a_q.pos < cab_floor)
					car_a_n.cab_up = car_a_q.cab_up | fbit(cab_floor);
			end
			if (cab_b) begin
				if (car_b_q.pos > cab_floor)
					car_b_n.cab_dn = car_b_q.cab_dn | fbit(cab_floor);
				else if (car_b_q.pos < cab_floor)
					car_b_n.cab_up = car_b_q.cab_up | fbit(cab_floor);
			end
			hall_up_n = hall_up_q | hall_up_set;
			hall_dn_n = hall_dn_q | hall_dn_set;
		end else begin
			// A tick counts a running countdown down. When nothing runs, or
			// the countdown ends on this tick, the active car takes its step.
			if (wait_q != 8'd0) wait_n = wait_q - 8'd1;
			if (wait_q[7:1] == 7'd0) begin
				if (sel_q) car_b_n = step.car;
				else car_a_n = step.car;
				hall_up_n = step.hall_up;
				hall_dn_n = step.hall_dn;
				sel_n     = sel_q ^ step.swap;
				sub_n     = step.sub_next;
				if (step.load_wait) wait_n = wait_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_a_q   <= '{pos: FLOOR_BOTTOM, target: FLOOR_BOTTOM, up: 1'b1, idle: 1'b1,
				stop: 1'b1, cab_up: 4'b0000, cab_dn: 4'b0000};
			car_b_q   <= '{pos: FLOOR_BOTTOM, target: FLOOR_BOTTOM, up: 1'b1, idle: 1'b1,
				stop: 1'b1, cab_up: 4'b0000, cab_dn: 4'b0000};
			hall_up_q <= 4'b0000;
			hall_dn_q <= 4'b0000;
			sel_q     <= 1'b0;
			sub_q     <= SUB_DECIDE;
			wait_q    <= 8'd0;
		end else if (advance) begin
			car_a_q   <= car_a_n;
			car_b_q   <= car_b_n;
			hall_up_q <= hall_up_n;
			hall_dn_q <= hall_dn_n;
			sel_q     <= sel_n;
			sub_q     <= sub_n;
			wait_q    <= wait_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The result shows the state as it stands after the item.
	always_ff @(posedge clk) begin
		if (advance) begin
			floor_a_q         <= car_a_n.pos;
			floor_b_q         <= car_b_n.pos;
			going_up_a_q      <= car_a_n.up;
			going_up_b_q      <= car_b_n.up;
			door_open_a_q     <= car_a_n.stop && !car_a_n.idle;
			door_open_b_q     <= car_b_n.stop && !car_b_n.idle;
			car_lamps_a_q     <= car_a_n.cab_up | car_a_n.cab_dn;
			car_lamps_b_q     <= car_b_n.cab_up | car_b_n.cab_dn;
			hall_up_lamps_q   <= hall_up_n;
			hall_down_lamps_q <= hall_dn_n;
			waiting_q         <= (wait_n != 8'd0);
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.floor_a         = floor_a_q;
	assign rsp.floor_b         = floor_b_q;
	assign rsp.going_up_a      = going_up_a_q;
	assign rsp.going_up_b      = going_up_b_q;
	assign rsp.door_open_a     = door_open_a_q;
	assign rsp.door_open_b     = door_open_b_q;
	assign rsp.car_lamps_a     = car_lamps_a_q;
	assign rsp.car_lamps_b     = car_lamps_b_q;
	assign rsp.hall_up_lamps   = hall_up_lamps_q;
	assign rsp.hall_down_lamps = hall_down_lamps_q;
	assign rsp.waiting         = waiting_q;

`ifndef SYNTH
	// A countdown only runs during a door stay or a move, never while deciding.
	a_wait_not_decide: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q != 8'd0 |-> sub_q != SUB_DECIDE)
		else $error("countdown running in decide step");

	// Both cars stay within the shaft.
	a_floor_range: assert property (@(posedge clk) disable iff (!arst_n)
		car_a_q.pos >= FLOOR_BOTTOM && car_a_q.pos <= FLOOR_TOP &&
		car_b_q.pos >= FLOOR_BOTTOM && car_b_q.pos <= FLOOR_TOP)
		else $error("car position out of range");

	// An item moved out of the input stage always shows up as a result.
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item produced no result");

	// While a result is stalled no further item may change the state.
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> $stable(wait_q) && $stable(sel_q) &&
			$stable(hall_up_q) && $stable(hall_dn_q))
		else $error("state changed while result stalled");
`endif

endmodule
`default_nettype wire
